### rtl/core/adam_box_constrained_update_macros.svh
// Assertion helpers for the Adam update engine.
// ASSERT_IMPLY checks a same-cycle implication, ASSERT_NEXT a next-cycle one.
`ifndef ADAM_BOX_CONSTRAINED_UPDATE_MACROS_SVH
`define ADAM_BOX_CONSTRAINED_UPDATE_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/core/abcu_pkg.sv
`timescale 1ns / 1ps
package abcu_pkg;

   // entry count
   localparam int DIMENSIONS_DEFAULT = 64;

   // fixed point constants
   localparam logic [24:0] ONE_Q24  = 25'd16777216;
   localparam logic [24:0] HALF_Q24 = 25'd8388608;
   localparam logic [32:0] EPS_Q16  = 33'd6554;

   // register reset values
   localparam logic [24:0] LR_RESET = 25'd4194304;
   localparam logic [24:0] B1_RESET = 25'd15099494;
   localparam logic [24:0] B2_RESET = 25'd16760439;

   // register indexes
   localparam int          CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_BETA_ONE      = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_BETA_TWO      = 2'd2;

   // function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   // serial unit widths
   localparam int MUL_AW   = 65;
   localparam int MUL_BW   = 32;
   localparam int MUL_ACCW = 98;
   localparam int SQ_W     = 64;
   localparam int SQ_RW    = 32;
   localparam int DV_NW    = 64;
   localparam int DV_DW    = 41;

   typedef struct packed {
      logic        func;
      logic [5:0]  index;
      logic [31:0] value;
      logic [31:0] lower_bound;
      logic [31:0] upper_bound;
   } req_type;

   typedef struct packed {
      logic [5:0]  entry;
      logic [31:0] position;
   } rsp_type;

   // one RAM word per entry
   typedef struct packed {
      logic [31:0] pos;
      logic [31:0] lo;
      logic [31:0] up;
      logic [31:0] m;
      logic [63:0] v;
   } entry_type;

   // sequencer to arithmetic units
   typedef struct packed {
      logic mul_start;
      logic mul_keep;
      logic sqrt_start;
      logic div_start;
   } unit_ctl_type;

   // arithmetic units to sequencer
   typedef struct packed {
      logic mul_busy;
      logic mul_done;
      logic sqrt_busy;
      logic sqrt_done;
      logic div_busy;
      logic div_done;
   } unit_sts_type;

endpackage

### rtl/core/abcu_ram.sv
`timescale 1ns / 1ps
module abcu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/abcu_mul.sv
`timescale 1ns / 1ps
// Shift-add multiplier: one multiplier bit per cycle, signed A, unsigned B,
// accumulating onto a bias or onto the previous result.
module abcu_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  abcu_pkg::unit_ctl_type          ctl,
   input  logic [abcu_pkg::MUL_AW-1:0]     a,
   input  logic [abcu_pkg::MUL_BW-1:0]     b,
   input  logic [abcu_pkg::MUL_ACCW-1:0]   bias,
   output logic [abcu_pkg::MUL_ACCW-1:0]   acc,
   output logic                            busy,
   output logic                            done
);

   localparam int CW = $clog2(abcu_pkg::MUL_BW);
   localparam logic [CW-1:0] LAST = CW'(abcu_pkg::MUL_BW - 1);

   logic [abcu_pkg::MUL_ACCW-1:0] acc_ff, acc_in, a_sh_ff, a_sh_in;
   logic [abcu_pkg::MUL_BW-1:0]   b_sh_ff, b_sh_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == LAST);
      if (ctl.mul_start) begin
         a_sh_in = {{(abcu_pkg::MUL_ACCW - abcu_pkg::MUL_AW){a[abcu_pkg::MUL_AW-1]}}, a};
         b_sh_in = b;
         acc_in  = ctl.mul_keep ? acc_ff : bias;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one partial product per cycle
         if (b_sh_ff[0]) begin
            acc_in = acc_ff + a_sh_ff;
         end
         a_sh_in = {a_sh_ff[abcu_pkg::MUL_ACCW-2:0], 1'b0};
         b_sh_in = {1'b0, b_sh_ff[abcu_pkg::MUL_BW-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff  <= acc_in;
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
   end

   assign acc  = acc_ff;
   assign busy = busy_ff;
   assign done = done_ff;

endmodule

### rtl/core/abcu_sqrt.sv
`timescale 1ns / 1ps
// Digit-by-digit integer square root, two radicand bits per cycle.
module abcu_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  abcu_pkg::unit_ctl_type        ctl,
   input  logic [abcu_pkg::SQ_W-1:0]     a,
   output logic [abcu_pkg::SQ_RW-1:0]    root,
   output logic                          busy,
   output logic                          done
);

   localparam int RW = abcu_pkg::SQ_RW;
   localparam int CW = $clog2(RW);
   localparam logic [CW-1:0] LAST = CW'(RW - 1);

   logic [abcu_pkg::SQ_W-1:0] a_sh_ff, a_sh_in;
   logic [RW+1:0]             rem_ff, rem_in;
   logic [RW-1:0]             root_ff, root_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      busy_ff, busy_in, done_ff, done_in;
   logic [RW+3:0]             rem_sh, trial;

   always_comb begin
      rem_sh  = {rem_ff, a_sh_ff[abcu_pkg::SQ_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      a_sh_in = a_sh_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == LAST);
      if (ctl.sqrt_start) begin
         a_sh_in = a;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= trial) begin
            rem_in  = (RW+2)'(rem_sh - trial);
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RW+1:0];
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         a_sh_in = {a_sh_ff[abcu_pkg::SQ_W-3:0], 2'b00};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_sh_ff <= a_sh_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign busy = busy_ff;
   assign done = done_ff;

endmodule

### rtl/core/abcu_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module abcu_div (
   input  logic                          clock,
   input  logic                          reset,
   input  abcu_pkg::unit_ctl_type        ctl,
   input  logic [abcu_pkg::DV_NW-1:0]    dividend,
   input  logic [abcu_pkg::DV_DW-1:0]    divisor,
   output logic [abcu_pkg::DV_NW-1:0]    quotient,
   output logic                          busy,
   output logic                          done
);

   localparam int NW = abcu_pkg::DV_NW;
   localparam int DW = abcu_pkg::DV_DW;
   localparam int CW = $clog2(NW);
   localparam logic [CW-1:0] LAST = CW'(NW - 1);

   logic [NW-1:0] dvd_ff, dvd_in, q_ff, q_in;
   logic [DW-1:0] dvs_ff, dvs_in, rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   rem_sh, diff;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[NW-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == LAST);
      if (ctl.div_start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = diff[DW-1:0];
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DW-1:0];
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         dvd_in = {dvd_ff[NW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign quotient = q_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

### rtl/core/adam_box_constrained_update.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall req_data  (func, index, value, bounds)
// rsp      out        rsp_valid/rsp_stall rsp_data  (entry, position)
// csr      in         csr_valid/csr_ready csr_index, csr_data
//
// From one acceptance to the next, a load passes only the output phase; a step
// fetches and updates its entry, and when it opens an iteration (entry 0) first
// updates the powers and step factor, with no division while the first moment
// power sits at one. Each unit pass: a start, its iterations, a done pulse.
// In sequence, the multiplier runs six or nine times, the others once or twice.
// After reset a clearing pass zeroes all DIMENSIONS words of the entry RAM; no
// transaction is accepted then.
// A result waits in an output register; the next transaction is accepted
// meanwhile and holds only at its own result while rsp_stall is high.
`include "adam_box_constrained_update_macros.svh"
module adam_box_constrained_update #(
   parameter int DIMENSIONS = abcu_pkg::DIMENSIONS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  abcu_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output abcu_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [abcu_pkg::CSR_IW-1:0] csr_index,
   input  logic [24:0]                 csr_data
);

   localparam int AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
   localparam int EW = $bits(abcu_pkg::entry_type);
   localparam int MACC = abcu_pkg::MUL_ACCW;

   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_FETCH = 5'd2;
   localparam logic [4:0] S_POW1  = 5'd3;
   localparam logic [4:0] S_POW2  = 5'd4;
   localparam logic [4:0] S_ROOT1 = 5'd5;
   localparam logic [4:0] S_NUM   = 5'd6;
   localparam logic [4:0] S_QUOT1 = 5'd7;
   localparam logic [4:0] S_MOM1  = 5'd8;
   localparam logic [4:0] S_MOM2  = 5'd9;
   localparam logic [4:0] S_SQG   = 5'd10;
   localparam logic [4:0] S_VAR1  = 5'd11;
   localparam logic [4:0] S_VAR2  = 5'd12;
   localparam logic [4:0] S_ROOT2 = 5'd13;
   localparam logic [4:0] S_PROD  = 5'd14;
   localparam logic [4:0] S_QUOT2 = 5'd15;
   localparam logic [4:0] S_UPD   = 5'd16;
   localparam logic [4:0] S_OUT   = 5'd17;

   logic [4:0]  state_ff, state_in;
   logic        launched_ff, launched_in;
   logic [24:0] lr_ff, lr_in, b1_ff, b1_in, b2_ff, b2_in;
   logic [24:0] b1p_ff, b1p_in, b2p_ff, b2p_in, s_ff, s_in;
   logic [31:0] factor_ff, factor_in;
   logic        func_ff, func_in;
   logic [5:0]  idx_ff, idx_in;
   logic [31:0] g_ff, g_in, pos_ff, pos_in, lo_ff, lo_in, up_ff, up_in, m_ff, m_in;
   logic [63:0] v_ff, v_in, prod_ff, prod_in, delta_ff, delta_in;
   logic [40:0] den_ff, den_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   abcu_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // unit plumbing
   abcu_pkg::unit_ctl_type ctl;
   abcu_pkg::unit_sts_type sts;
   logic [abcu_pkg::MUL_AW-1:0] mul_a;
   logic [abcu_pkg::MUL_BW-1:0] mul_b;
   logic [MACC-1:0]             mul_bias, mul_acc;
   logic [abcu_pkg::SQ_W-1:0]   sq_a;
   logic [abcu_pkg::SQ_RW-1:0]  sq_root;
   logic [abcu_pkg::DV_NW-1:0]  dv_q;
   logic [abcu_pkg::DV_DW-1:0]  dv_divisor;
   logic                        mul_go, sqrt_go, div_go, keep;

   // entry RAM
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0] ram_wdata, ram_rdata;
   abcu_pkg::entry_type rd_entry;

   // datapath helpers
   logic [31:0] g_abs, m_abs, m_sat, x_sat, x_hi, x_new;
   logic [24:0] omb1, omb2, d1, d2;
   logic [65:0] x_ext;
   logic        req_fire, out_fire, out_of_range;

   assign rd_entry = abcu_pkg::entry_type'(ram_rdata);
   assign g_abs    = g_ff[31] ? (32'd0 - g_ff) : g_ff;
   assign m_abs    = m_ff[31] ? (32'd0 - m_ff) : m_ff;
   assign omb1     = abcu_pkg::ONE_Q24 - b1_ff;
   assign omb2     = abcu_pkg::ONE_Q24 - b2_ff;
   assign d1       = abcu_pkg::ONE_Q24 - b1p_ff;
   assign d2       = abcu_pkg::ONE_Q24 - b2p_ff;
   assign req_fire = req_valid && !req_stall;
   assign out_fire = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign out_of_range = 32'(req_data.index) >= DIMENSIONS;

   // new first moment: floor(acc / 2^24), saturated
   always_comb begin
      if ((mul_acc[MACC-1:55] == '0) || (mul_acc[MACC-1:55] == '1)) begin
         m_sat = mul_acc[55:24];
      end else begin
         m_sat = mul_acc[MACC-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
   end

   // position update, saturate, then clamp (lower limit wins)
   always_comb begin
      if (m_ff[31]) begin
         x_ext = {{34{pos_ff[31]}}, pos_ff} + {2'b00, delta_ff};
      end else begin
         x_ext = {{34{pos_ff[31]}}, pos_ff} - {2'b00, delta_ff};
      end
      if ((x_ext[65:31] == '0) || (x_ext[65:31] == '1)) begin
         x_sat = x_ext[31:0];
      end else begin
         x_sat = x_ext[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      x_hi  = ($signed(x_sat) > $signed(up_ff)) ? up_ff : x_sat;
      x_new = ($signed(x_hi) < $signed(lo_ff)) ? lo_ff : x_hi;
   end

   // operand selection per phase
   always_comb begin
      mul_go     = 1'b0;
      sqrt_go    = 1'b0;
      div_go     = 1'b0;
      keep       = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      mul_bias   = '0;
      sq_a       = v_ff;
      dv_divisor = den_ff;
      case (state_ff)
         S_POW1: begin
            mul_go = 1'b1; mul_a = {40'd0, b1p_ff}; mul_b = {7'd0, b1_ff};
            mul_bias = MACC'(abcu_pkg::HALF_Q24);
         end
         S_POW2: begin
            mul_go = 1'b1; mul_a = {40'd0, b2p_ff}; mul_b = {7'd0, b2_ff};
            mul_bias = MACC'(abcu_pkg::HALF_Q24);
         end
         S_ROOT1: begin
            sqrt_go = 1'b1; sq_a = {15'd0, d2, 24'd0};
         end
         S_NUM: begin
            mul_go = 1'b1; mul_a = {40'd0, lr_ff}; mul_b = {7'd0, s_ff};
         end
         S_QUOT1: begin
            div_go = (d1 != '0); dv_divisor = {16'd0, d1};
         end
         S_MOM1: begin
            mul_go = 1'b1; mul_a = {{33{m_ff[31]}}, m_ff}; mul_b = {7'd0, b1_ff};
            mul_bias = MACC'(abcu_pkg::HALF_Q24);
         end
         S_MOM2: begin
            mul_go = 1'b1; keep = 1'b1;
            mul_a = {{33{g_ff[31]}}, g_ff}; mul_b = {7'd0, omb1};
         end
         S_SQG: begin
            mul_go = 1'b1; mul_a = {33'd0, g_abs}; mul_b = g_abs;
         end
         S_VAR1: begin
            mul_go = 1'b1; mul_a = {1'b0, v_ff}; mul_b = {7'd0, b2_ff};
            mul_bias = MACC'(abcu_pkg::HALF_Q24);
         end
         S_VAR2: begin
            mul_go = 1'b1; keep = 1'b1;
            mul_a = {1'b0, prod_ff}; mul_b = {7'd0, omb2};
         end
         S_ROOT2: begin
            sqrt_go = 1'b1;
         end
         S_PROD: begin
            mul_go = 1'b1; mul_a = {33'd0, factor_ff}; mul_b = m_abs;
         end
         S_QUOT2: begin
            div_go = 1'b1;
         end
         default: begin
         end
      endcase
      ctl.mul_start  = mul_go && !launched_ff;
      ctl.mul_keep   = keep;
      ctl.sqrt_start = sqrt_go && !launched_ff;
      ctl.div_start  = div_go && !launched_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      launched_in  = launched_ff;
      lr_in        = lr_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b1p_in       = b1p_ff;
      b2p_in       = b2p_ff;
      s_in         = s_ff;
      factor_in    = factor_ff;
      func_in      = func_ff;
      idx_in       = idx_ff;
      g_in         = g_ff;
      pos_in       = pos_ff;
      lo_in        = lo_ff;
      up_in        = up_ff;
      m_in         = m_ff;
      v_in         = v_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      delta_in     = delta_ff;
      clr_in       = clr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = AW'(idx_ff);
      ram_raddr    = AW'(req_data.index);
      ram_wdata    = {pos_ff, lo_ff, up_ff, m_ff, v_ff};

      // a unit started in this phase: wait for its done pulse
      if (ctl.mul_start || ctl.sqrt_start || ctl.div_start) begin
         launched_in = 1'b1;
      end

      // configuration writes, out-of-range values ignored
      if (csr_valid) begin
         unique case (csr_index)
            abcu_pkg::CSR_LEARNING_RATE: begin
               if ((csr_data != '0) && (csr_data <= abcu_pkg::ONE_Q24)) lr_in = csr_data;
            end
            abcu_pkg::CSR_BETA_ONE: begin
               if (csr_data <= abcu_pkg::ONE_Q24) b1_in = csr_data;
            end
            abcu_pkg::CSR_BETA_TWO: begin
               if (csr_data <= abcu_pkg::ONE_Q24) b2_in = csr_data;
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(DIMENSIONS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_data.func;
               idx_in  = req_data.index;
               g_in    = req_data.value;
               if (out_of_range) begin
                  state_in = S_IDLE;
               end else if (req_data.func == abcu_pkg::FUNC_LOAD) begin
                  pos_in   = req_data.value;
                  lo_in    = req_data.lower_bound;
                  up_in    = req_data.upper_bound;
                  m_in     = '0;
                  v_in     = '0;
                  state_in = S_OUT;
               end else begin
                  ram_re   = 1'b1;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            pos_in   = rd_entry.pos;
            lo_in    = rd_entry.lo;
            up_in    = rd_entry.up;
            m_in     = rd_entry.m;
            v_in     = rd_entry.v;
            state_in = (idx_ff == '0) ? S_POW1 : S_MOM1;
         end
         S_POW1: begin
            if (sts.mul_done) begin
               b1p_in = mul_acc[48:24]; launched_in = 1'b0; state_in = S_POW2;
            end
         end
         S_POW2: begin
            if (sts.mul_done) begin
               b2p_in = mul_acc[48:24]; launched_in = 1'b0; state_in = S_ROOT1;
            end
         end
         S_ROOT1: begin
            if (sts.sqrt_done) begin
               s_in = sq_root[24:0]; launched_in = 1'b0; state_in = S_NUM;
            end
         end
         S_NUM: begin
            if (sts.mul_done) begin
               prod_in = mul_acc[63:0]; launched_in = 1'b0; state_in = S_QUOT1;
            end
         end
         S_QUOT1: begin
            // first moment power at one: no division
            if (d1 == '0) begin
               factor_in = (prod_ff != '0) ? 32'hFFFF_FFFF : 32'd0;
               state_in  = S_MOM1;
            end else if (sts.div_done) begin
               factor_in   = (dv_q[63:32] != '0) ? 32'hFFFF_FFFF : dv_q[31:0];
               launched_in = 1'b0;
               state_in    = S_MOM1;
            end
         end
         S_MOM1: begin
            if (sts.mul_done) begin
               launched_in = 1'b0; state_in = S_MOM2;
            end
         end
         S_MOM2: begin
            if (sts.mul_done) begin
               m_in = m_sat; launched_in = 1'b0; state_in = S_SQG;
            end
         end
         S_SQG: begin
            if (sts.mul_done) begin
               prod_in = mul_acc[63:0]; launched_in = 1'b0; state_in = S_VAR1;
            end
         end
         S_VAR1: begin
            if (sts.mul_done) begin
               launched_in = 1'b0; state_in = S_VAR2;
            end
         end
         S_VAR2: begin
            if (sts.mul_done) begin
               v_in = mul_acc[87:24]; launched_in = 1'b0; state_in = S_ROOT2;
            end
         end
         S_ROOT2: begin
            if (sts.sqrt_done) begin
               den_in      = {({1'b0, sq_root} + abcu_pkg::EPS_Q16), 8'd0};
               launched_in = 1'b0;
               state_in    = S_PROD;
            end
         end
         S_PROD: begin
            if (sts.mul_done) begin
               prod_in = mul_acc[63:0]; launched_in = 1'b0; state_in = S_QUOT2;
            end
         end
         S_QUOT2: begin
            if (sts.div_done) begin
               delta_in = dv_q; launched_in = 1'b0; state_in = S_UPD;
            end
         end
         S_UPD: begin
            pos_in   = x_new;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_fire) begin
               ram_we               = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_data_in.entry    = idx_ff;
               rsp_data_in.position = pos_ff;
               if (func_ff == abcu_pkg::FUNC_LOAD) begin
                  b1p_in = abcu_pkg::ONE_Q24;
                  b2p_in = abcu_pkg::ONE_Q24;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         launched_ff  <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         lr_ff        <= abcu_pkg::LR_RESET;
         b1_ff        <= abcu_pkg::B1_RESET;
         b2_ff        <= abcu_pkg::B2_RESET;
         b1p_ff       <= abcu_pkg::ONE_Q24;
         b2p_ff       <= abcu_pkg::ONE_Q24;
         factor_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         lr_ff        <= lr_in;
         b1_ff        <= b1_in;
         b2_ff        <= b2_in;
         b1p_ff       <= b1p_in;
         b2p_ff       <= b2p_in;
         factor_ff    <= factor_in;
      end
      s_ff        <= s_in;
      func_ff     <= func_in;
      idx_ff      <= idx_in;
      g_ff        <= g_in;
      pos_ff      <= pos_in;
      lo_ff       <= lo_in;
      up_ff       <= up_in;
      m_ff        <= m_in;
      v_ff        <= v_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      delta_ff    <= delta_in;
      rsp_data_ff <= rsp_data_in;
   end

   abcu_ram #(.WIDTH(EW), .DEPTH(DIMENSIONS)) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   abcu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .a     (mul_a),
      .b     (mul_b),
      .bias  (mul_bias),
      .acc   (mul_acc),
      .busy  (sts.mul_busy),
      .done  (sts.mul_done)
   );

   abcu_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .a     (sq_a),
      .root  (sq_root),
      .busy  (sts.sqrt_busy),
      .done  (sts.sqrt_done)
   );

   abcu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .dividend (prod_ff),
      .divisor  (dv_divisor),
      .quotient (dv_q),
      .busy     (sts.div_busy),
      .done     (sts.div_done)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // a fresh result only comes out of the output phase
   `ASSERT_IMPLY(a_rsp_from_out, clock, reset, $rose(rsp_valid), $past(state_ff) == S_OUT, "result not from output phase")
   // arithmetic units never overlap
   `ASSERT_IMPLY(a_one_unit, clock, reset, 1'b1, $onehot0({sts.mul_busy, sts.sqrt_busy, sts.div_busy}), "units overlap")
   // bias-correction powers never exceed one
   `ASSERT_NEXT(a_powers_bounded, clock, reset, sts.mul_done, (b1p_ff <= abcu_pkg::ONE_Q24) && (b2p_ff <= abcu_pkg::ONE_Q24), "power above one")

endmodule

### bench/tb_adam_box_constrained_update.sv
`timescale 1ns / 1ps
module tb_adam_box_constrained_update;

   localparam int    ENTRIES     = abcu_pkg::DIMENSIONS_DEFAULT;
   localparam int    CYCLE_LIMIT = 4000000;
   localparam int    IDLE_PCT    = 17;
   localparam logic [24:0] HALF_ONE = 25'd8388608;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   abcu_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   abcu_pkg::rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [abcu_pkg::CSR_IW-1:0] csr_index = abcu_pkg::CSR_LEARNING_RATE;
   logic [24:0] csr_data = '0;

   adam_box_constrained_update uut (.*);

   always #4 clock = ~clock;

   // shadow copy of the engine state
   logic [24:0]        lr_q, b1_q, b2_q;
   logic signed [31:0] pos_q [ENTRIES];
   logic signed [31:0] lo_q  [ENTRIES];
   logic signed [31:0] up_q  [ENTRIES];
   logic signed [31:0] mom1_q[ENTRIES];
   logic [63:0]        mom2_q[ENTRIES];
   logic [24:0]        b1pow_q, b2pow_q;
   logic [31:0]        factor_q;

   abcu_pkg::rsp_type pending_positions[$];
   int          errors = 0;
   int          cycles = 0;
   int          sent = 0;
   int          checked = 0;
   int          hold_cycles = 0;
   bit          quiet = 1'b0;

   function automatic logic [63:0] root64(logic [63:0] a);
      logic [63:0] r, t;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= a) r = t;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] clip32(longint x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   // new iteration: advance powers, recompute step factor
   function automatic void advance_powers();
      logic [63:0] s, num, f, d1;
      b1pow_q = 25'((64'(b1pow_q) * b1_q + HALF_ONE) >> 24);
      b2pow_q = 25'((64'(b2pow_q) * b2_q + HALF_ONE) >> 24);
      s   = root64((64'(abcu_pkg::ONE_Q24) - b2pow_q) << 24);
      num = 64'(lr_q) * s;
      d1  = 64'(abcu_pkg::ONE_Q24) - b1pow_q;
      if (d1 == 0) factor_q = (num != 0) ? 32'hffffffff : 32'h0;
      else begin
         f = num / d1;
         factor_q = (f > 64'hffffffff) ? 32'hffffffff : f[31:0];
      end
   endfunction

   // expected position for one accepted transaction
   function automatic abcu_pkg::rsp_type predict_position(abcu_pkg::req_type r);
      abcu_pkg::rsp_type o;
      int          k;
      longint      g, t, x;
      logic [63:0] gmag, mmag, den, delta;
      logic [127:0] acc;
      k = r.index;
      g = longint'($signed(r.value));
      if (r.func == abcu_pkg::FUNC_LOAD) begin
         pos_q[k] = r.value; lo_q[k] = r.lower_bound; up_q[k] = r.upper_bound;
         mom1_q[k] = '0; mom2_q[k] = '0;
         b1pow_q = abcu_pkg::ONE_Q24; b2pow_q = abcu_pkg::ONE_Q24;
      end else begin
         if (k == 0) advance_powers();
         t = longint'(b1_q) * longint'(mom1_q[k])
             + longint'(abcu_pkg::ONE_Q24 - b1_q) * g + longint'(HALF_ONE);
         mom1_q[k] = clip32(t >>> 24);
         gmag = (g < 0) ? 64'(-g) : 64'(g);
         acc = 128'(mom2_q[k]) * 128'(b2_q)
               + 128'(gmag * gmag) * 128'(abcu_pkg::ONE_Q24 - b2_q) + 128'(HALF_ONE);
         mom2_q[k] = acc[87:24];
         den  = (root64(mom2_q[k]) + 64'd6554) << 8;
         mmag = (mom1_q[k] < 0) ? 64'(-longint'(mom1_q[k])) : 64'(mom1_q[k]);
         delta = (64'(factor_q) * mmag) / den;
         x = longint'(pos_q[k]);
         if (mom1_q[k] < 0) x = x + longint'(delta);
         else x = x - longint'(delta);
         x = clip32(x);
         if (x > longint'(up_q[k])) x = up_q[k];
         if (x < longint'(lo_q[k])) x = lo_q[k];
         pos_q[k] = x[31:0];
      end
      o.entry = r.index;
      o.position = pos_q[k];
      return o;
   endfunction

   // offer one transaction, predict on acceptance, then maybe idle
   task automatic send_item(abcu_pkg::req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      pending_positions.push_back(predict_position(r));
      sent++;
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic load_entry(int k, logic [31:0] p, logic [31:0] l, logic [31:0] u);
      abcu_pkg::req_type r;
      r = '{func: abcu_pkg::FUNC_LOAD, index: k[5:0], value: p, lower_bound: l,
            upper_bound: u};
      send_item(r);
   endtask

   task automatic step_entry(int k, logic [31:0] g);
      abcu_pkg::req_type r;
      r = '{func: abcu_pkg::FUNC_STEP, index: k[5:0], value: g,
            lower_bound: $urandom, upper_bound: $urandom};
      send_item(r);
   endtask

   // wait until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register write; the caller drops csr_valid after its last write
   task automatic csr_write(logic [abcu_pkg::CSR_IW-1:0] idx, logic [24:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         abcu_pkg::CSR_LEARNING_RATE: if (d >= 1 && d <= abcu_pkg::ONE_Q24) lr_q = d;
         abcu_pkg::CSR_BETA_ONE:      if (d <= abcu_pkg::ONE_Q24) b1_q = d;
         abcu_pkg::CSR_BETA_TWO:      if (d <= abcu_pkg::ONE_Q24) b2_q = d;
         default: ;
      endcase
   endtask

   task automatic set_rates(logic [24:0] lr, logic [24:0] b1, logic [24:0] b2);
      drain();
      csr_write(abcu_pkg::CSR_LEARNING_RATE, lr);
      csr_write(abcu_pkg::CSR_BETA_ONE, b1);
      csr_write(abcu_pkg::CSR_BETA_TWO, b2);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_grad();
      case ($urandom_range(9))
         0: return $urandom;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         default: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      endcase
   endfunction

   task automatic test_loads();
      load_entry(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      load_entry(1, 32'h80000000, 32'h80000000, 32'h7fffffff);
      load_entry(2, 32'h00010000, 32'h00050000, 32'h00020000);   // crossed box
      load_entry(3, 32'h0, 32'hfff00000, 32'h00100000);
   endtask

   task automatic test_first_steps();
      step_entry(1, 32'h00010000);   // step factor still zero
      step_entry(0, 32'h7fffffff);
      step_entry(1, 32'h80000000);
      step_entry(2, 32'h0);
      step_entry(3, 32'hffff0000);
      step_entry(0, 32'h00008000);
   endtask

   task automatic test_config_extremes();
      set_rates(25'd1, 25'd0, 25'd0);
      step_entry(0, 32'h00020000); step_entry(3, 32'hfffe0000);
      set_rates(abcu_pkg::ONE_Q24, abcu_pkg::ONE_Q24, abcu_pkg::ONE_Q24);
      step_entry(0, 32'h00020000); step_entry(3, 32'h7fffffff);
      // out of range writes leave the registers alone
      set_rates(25'd0, 25'h1ffffff, abcu_pkg::ONE_Q24 + 25'd1);
      step_entry(0, 32'hfff00000);
      set_rates(abcu_pkg::LR_RESET, abcu_pkg::B1_RESET, abcu_pkg::B2_RESET);
      load_entry(0, 32'h00030000, 32'hffff0000, 32'h00080000);   // restarts powers
      step_entry(1, 32'h00001000);
      step_entry(0, 32'h00001000);
   endtask

   task automatic test_backpressure();
      drain();
      hold_cycles = 3000;
      for (int i = 0; i < 12; i++) step_entry(i % 4, rand_grad());
   endtask

   task automatic test_random(int total);
      int n, width, k;
      logic [31:0] a, b;
      for (int i = 0; i < ENTRIES; i++) begin
         a = $urandom; b = $urandom;
         if ($urandom_range(9) == 0) load_entry(i, $urandom, a, b);
         else load_entry(i, $urandom, ($signed(a) < $signed(b)) ? a : b,
                         ($signed(a) < $signed(b)) ? b : a);
      end
      n = ENTRIES;
      while (n < total) begin
         case ($urandom_range(9))
            0: begin
               set_rates(25'($urandom_range(1, abcu_pkg::ONE_Q24)),
                         25'($urandom_range(0, abcu_pkg::ONE_Q24)),
                         25'($urandom_range(0, abcu_pkg::ONE_Q24)));
               quiet = ($urandom_range(3) == 0);
            end
            1: begin   // reload, possibly with any bit pattern
               k = $urandom_range(ENTRIES - 1);
               load_entry(k, $urandom, $urandom, $urandom); n++;
            end
            2: begin   // out of order steps
               step_entry($urandom_range(ENTRIES - 1), rand_grad()); n++;
            end
            default: begin   // one iteration over a prefix of the entries
               width = ($urandom_range(4) == 0) ? ENTRIES : $urandom_range(1, 8);
               for (int j = 0; j < width; j++) step_entry(j, rand_grad());
               n += width;
            end
         endcase
      end
      quiet = 1'b0;
   endtask

   // receiver stall: random idling, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      abcu_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_positions.size() == 0) begin
            $display("%0t: unexpected result entry %0d position %h",
                     $time, rsp_data.entry, rsp_data.position);
            errors++;
         end else begin
            want = pending_positions.pop_front();
            checked++;
            if (rsp_data.entry !== want.entry) begin
               $display("%0t: entry expected %0d actual %0d",
                        $time, want.entry, rsp_data.entry);
               errors++;
            end
            if (rsp_data.position !== want.position) begin
               $display("%0t: position of entry %0d expected %h actual %h",
                        $time, want.entry, want.position, rsp_data.position);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_positions.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      lr_q = abcu_pkg::LR_RESET; b1_q = abcu_pkg::B1_RESET; b2_q = abcu_pkg::B2_RESET;
      b1pow_q = abcu_pkg::ONE_Q24; b2pow_q = abcu_pkg::ONE_Q24; factor_q = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         pos_q[i] = '0; lo_q[i] = '0; up_q[i] = '0;
         mom1_q[i] = '0; mom2_q[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_loads();
      test_first_steps();
      test_config_extremes();
      test_backpressure();
      test_random(1900);
      drain();
      repeat (500) @(posedge clock);
      $display("Sent %0d load and step transactions, checked %0d results,", sent, checked);
      $display("across several rate settings, crossed boxes and a long output hold-off.");
      if (errors == 0 && pending_positions.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, pending_positions.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
